/* src/ncc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Types and constants shared by the nearest-centroid classifier modules.
// ----------------------------------------------------------------------------
package ncc_pkg;

  localparam int CompW      = 16;
  localparam int SlotW      = 5;
  localparam int IndexW     = 5;
  localparam int ScoreW     = 33;
  localparam int NumPlatesW = 6;
  localparam int ProdW      = 2 * CompW;

  localparam logic [NumPlatesW-1:0] NumPlatesRst = NumPlatesW'(1);

  // -2.0 in Q2.30
  localparam logic signed [ScoreW-1:0] StartScore = -33'sd2147483648;

  typedef enum logic {
    OpLoad     = 1'b0,
    OpClassify = 1'b1
  } op_e;

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  // Tag that travels with each table read through the dot pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tag_t;

endpackage

/* src/ncc_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_table
// Centroid store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ncc_table #(
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  ncc_pkg::vec_t      wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output ncc_pkg::vec_t      rdata_o
);
  import ncc_pkg::*;

  vec_t mem_q [Depth];
  vec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ncc_dot_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_dot_unit
// Shared dot-product and compare unit: products stage, then sum and
// running-max update. Flags done once the last candidate is folded in.
// ----------------------------------------------------------------------------
module ncc_dot_unit #(
  parameter int IdxW = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ncc_pkg::vec_t                  query_i,
  input  ncc_pkg::vec_t                  cent_i,
  input  ncc_pkg::tag_t                  tag_i,
  input  logic [IdxW-1:0]                idx_i,
  output logic                           done_o,
  output logic [ncc_pkg::IndexW-1:0]     plate_index_o,
  output logic signed [ncc_pkg::ScoreW-1:0] best_score_o
);
  import ncc_pkg::*;

  tag_t                     tag_q;
  logic [IdxW-1:0]          idx_q;
  logic signed [ProdW-1:0]  px_q, py_q, pz_q;

  logic signed [ScoreW-1:0] dot;
  logic signed [ScoreW-1:0] base;
  logic signed [ScoreW-1:0] best_q, best_d;
  logic [IdxW-1:0]          best_idx_q, best_idx_d;
  logic                     done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      done_q <= 1'b0;
    end else begin
      tag_q  <= tag_i;
      done_q <= tag_q.vld & tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_i;
    px_q  <= query_i.x * cent_i.x;
    py_q  <= query_i.y * cent_i.y;
    pz_q  <= query_i.z * cent_i.z;
    if (tag_q.vld) begin
      best_q     <= best_d;
      best_idx_q <= best_idx_d;
    end
  end

  always_comb begin
    dot        = ScoreW'(px_q) + ScoreW'(py_q) + ScoreW'(pz_q);
    base       = tag_q.first ? StartScore : best_q;
    best_d     = base;
    best_idx_d = tag_q.first ? '0 : best_idx_q;
    if (dot > base) begin
      best_d     = dot;
      best_idx_d = idx_q;
    end
  end

  assign done_o        = done_q;
  assign plate_index_o = IndexW'(best_idx_q);
  assign best_score_o  = best_q;

endmodule

/* src/ncc_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_seq
// Sequencer: takes commands, issues one table read per cycle during a
// search and waits for the dot unit to finish.
// ----------------------------------------------------------------------------
module ncc_seq #(
  parameter int MaxPlates = 32,
  parameter int IdxW      = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              classify_i,
  input  ncc_pkg::vec_t                     vec_i,
  input  logic [ncc_pkg::NumPlatesW-1:0]    num_plates_i,
  input  logic                              done_i,
  output logic                              busy_o,
  output ncc_pkg::vec_t                     query_o,
  output logic [IdxW-1:0]                   raddr_o,
  output ncc_pkg::tag_t                     tag_o,
  output logic [IdxW-1:0]                   idx_o
);
  import ncc_pkg::*;

  localparam int CntW = $clog2(MaxPlates + 1);
  localparam int NW   = (CntW > NumPlatesW) ? CntW : NumPlatesW;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SWait
  } state_e;

  state_e          state_q;
  vec_t            query_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [IdxW-1:0] last_q;
  logic [IdxW-1:0] last_d;
  tag_t            tag_q;
  tag_t            tag_d;
  logic [IdxW-1:0] idx_q;
  logic [NW-1:0]   cnt;

  always_comb begin
    cnt = NW'(num_plates_i);
    if (cnt == '0) begin
      cnt = NW'(1);
    end else if (cnt > NW'(MaxPlates)) begin
      cnt = NW'(MaxPlates);
    end
    last_d = IdxW'(cnt - NW'(1));
  end

  always_comb begin
    tag_d = '0;
    if (state_q == SScan) begin
      tag_d.vld   = 1'b1;
      tag_d.first = (rd_idx_q == '0);
      tag_d.last  = (rd_idx_q == last_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      tag_q    <= '0;
      rd_idx_q <= '0;
      last_q   <= '0;
    end else begin
      tag_q <= tag_d;
      case (state_q)
        SIdle: begin
          if (start_i && classify_i) begin
            last_q   <= last_d;
            rd_idx_q <= '0;
            state_q  <= SScan;
          end
        end
        SScan: begin
          if (rd_idx_q == last_q) begin
            state_q <= SWait;
          end else begin
            rd_idx_q <= rd_idx_q + IdxW'(1);
          end
        end
        SWait: begin
          if (done_i) begin
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= rd_idx_q;
    if (state_q == SIdle && start_i && classify_i) begin
      query_q <= vec_i;
    end
  end

  assign busy_o  = (state_q != SIdle);
  assign query_o = query_q;
  assign raddr_o = rd_idx_q;
  assign tag_o   = tag_q;
  assign idx_o   = idx_q;

endmodule

/* src/nearest_centroid_classifier_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_unit
// Max-dot-product search over a table of Q1.15 centroids; returns the
// winning slot and its Q2.30 score.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | word
//  command  | start, busy                 | operation, slot, vec_x/y/z
//  config   | cfg_valid_i, cfg_ready_o    | cfg_data_i (num_plates)
//  result   | done_o strobe, no backpres. | plate_index_o, best_score_o
//
//  Load: busy stays low, no result.
//  Classify: busy while the searched plates are scanned, with one table
//  read per cycle through the single dot/compare unit.
//  done_o is high for one cycle, in the last busy cycle.
//  Reset clears control and num_plates (to 1); the table is not cleared.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier_unit #(
  parameter int MAX_PLATES = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation_i,
  input  logic [ncc_pkg::SlotW-1:0]            slot_i,
  input  logic signed [ncc_pkg::CompW-1:0]     vec_x_i,
  input  logic signed [ncc_pkg::CompW-1:0]     vec_y_i,
  input  logic signed [ncc_pkg::CompW-1:0]     vec_z_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ncc_pkg::NumPlatesW-1:0]       cfg_data_i,
  output logic                                 done_o,
  output logic [ncc_pkg::IndexW-1:0]           plate_index_o,
  output logic signed [ncc_pkg::ScoreW-1:0]    best_score_o
);
  import ncc_pkg::*;

  localparam int AW = (MAX_PLATES > 1) ? $clog2(MAX_PLATES) : 1;

  logic [NumPlatesW-1:0] num_plates_q;
  logic                  accept;
  logic                  classify;
  logic                  we;
  vec_t                  vec_in;
  vec_t                  query;
  vec_t                  cent;
  logic [AW-1:0]         raddr;
  tag_t                  tag;
  logic [AW-1:0]         idx;
  logic                  done;

  assign accept   = start && !busy;
  assign classify = (op_e'(operation_i) == OpClassify);
  assign we       = accept && !classify && (32'(slot_i) < 32'(MAX_PLATES));
  assign vec_in   = '{x: vec_x_i, y: vec_y_i, z: vec_z_i};
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_plates_q <= NumPlatesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_plates_q <= cfg_data_i;
    end
  end

  ncc_seq #(
    .MaxPlates (MAX_PLATES),
    .IdxW      (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .classify_i   (classify),
    .vec_i        (vec_in),
    .num_plates_i (num_plates_q),
    .done_i       (done),
    .busy_o       (busy),
    .query_o      (query),
    .raddr_o      (raddr),
    .tag_o        (tag),
    .idx_o        (idx)
  );

  ncc_table #(
    .Depth (MAX_PLATES),
    .AddrW (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(slot_i)),
    .wdata_i (vec_in),
    .raddr_i (raddr),
    .rdata_o (cent)
  );

  ncc_dot_unit #(
    .IdxW (AW)
  ) u_dot (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_i       (query),
    .cent_i        (cent),
    .tag_i         (tag),
    .idx_i         (idx),
    .done_o        (done),
    .plate_index_o (plate_index_o),
    .best_score_o  (best_score_o)
  );

  assign done_o = done;

endmodule

/* src/ncc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_checker
// Port-level checks on command and result sequencing.
// ----------------------------------------------------------------------------
module ncc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic operation_i,
  input logic done_o
);
  import ncc_pkg::*;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result while not busy");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after result");

  a_classify_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_e'(operation_i) == OpClassify)) |=> busy)
    else $error("classify did not raise busy");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_e'(operation_i) == OpLoad)) |=> (!done_o && !busy))
    else $error("load produced a result or busy");

endmodule

bind nearest_centroid_classifier_unit ncc_checker u_ncc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .operation_i (operation_i),
  .done_o      (done_o)
);

/* test/nearest_centroid_classifier_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_unit_test
// Self-checking bench for the centroid search unit. Centroid loads and queries
// go in through the command port. A shadow centroid table predicts the winning
// slot and score of each query, and every done strobe is checked against that
// prediction. The plate count is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier_unit_test;
  import ncc_pkg::*;

  localparam int NumSlots    = 32;
  localparam int DrainCycles = 40;
  localparam int StallLimit  = 2000;

  localparam comp_t QMin  = 16'sh8000;
  localparam comp_t QMax  = 16'sh7fff;
  localparam comp_t QZero = 16'sh0000;

  typedef struct {
    op_e              op;
    logic [SlotW-1:0] slot;
    vec_t             v;
  } plate_cmd_t;

  typedef struct {
    logic [IndexW-1:0]        index;
    logic signed [ScoreW-1:0] score;
  } plate_match_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        start       = 1'b0;
  logic                        busy;
  logic                        operation_i = 1'b0;
  logic [SlotW-1:0]            slot_i      = '0;
  logic signed [CompW-1:0]     vec_x_i     = '0;
  logic signed [CompW-1:0]     vec_y_i     = '0;
  logic signed [CompW-1:0]     vec_z_i     = '0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [NumPlatesW-1:0]       cfg_data_i  = '0;
  logic                        done_o;
  logic [IndexW-1:0]           plate_index_o;
  logic signed [ScoreW-1:0]    best_score_o;

  // command words waiting to be driven, and the generator's view of the table
  plate_cmd_t           cmd_queue [$];
  vec_t                 shadow [NumSlots];
  logic [NumSlots-1:0]  seeded = '0;

  // predictor state, updated on accepted words only
  vec_t                  centroids [NumSlots];
  logic [NumPlatesW-1:0] plate_count = NumPlatesRst;
  plate_match_t          pending_matches [$];

  int  idle_pct     = 0;
  bit  hold         = 1'b0;
  bit  word_taken   = 1'b0;
  int  stall_cycles = 0;
  int  mismatches   = 0;
  int  n_loads      = 0;
  int  n_queries    = 0;
  int  n_results    = 0;
  int  mid_plates   = 0;

  nearest_centroid_classifier_unit #(
    .MAX_PLATES(NumSlots)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .slot_i       (slot_i),
    .vec_x_i      (vec_x_i),
    .vec_y_i      (vec_y_i),
    .vec_z_i      (vec_z_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .plate_index_o(plate_index_o),
    .best_score_o (best_score_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // command driver
  always @(negedge clk_i) begin : driver
    plate_cmd_t nxt;
    if (rst_ni && (!start || word_taken)) begin
      if (!hold && cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = cmd_queue.pop_front();
        start       <= 1'b1;
        operation_i <= nxt.op;
        slot_i      <= nxt.slot;
        vec_x_i     <= nxt.v.x;
        vec_y_i     <= nxt.v.y;
        vec_z_i     <= nxt.v.z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance, prediction, result check and watchdog
  always @(posedge clk_i) begin : monitor
    plate_match_t want;
    vec_t         q;
    longint       best;
    longint       dot;
    int           n;
    if (rst_ni) begin
      word_taken = start && !busy;
      if (cfg_valid_i && cfg_ready_o) begin
        plate_count = cfg_data_i;
      end
      if (done_o) begin
        n_results++;
        if (pending_matches.size() == 0) begin
          $error("result with no query pending: plate_index %0d, best_score %0d",
                 plate_index_o, best_score_o);
          mismatches++;
        end else begin
          want = pending_matches.pop_front();
          if (plate_index_o !== want.index) begin
            $error("plate_index: expected %0d, got %0d", want.index, plate_index_o);
            mismatches++;
          end
          if (best_score_o !== want.score) begin
            $error("best_score: expected %0d, got %0d", want.score, best_score_o);
            mismatches++;
          end
        end
      end
      if (word_taken) begin
        q.x = vec_x_i;
        q.y = vec_y_i;
        q.z = vec_z_i;
        if (operation_i == OpLoad) begin
          centroids[slot_i] = q;
        end else begin
          n = plate_count;
          if (n == 0) n = 1;
          if (n > NumSlots) n = NumSlots;
          best = longint'(StartScore);
          want.index = '0;
          for (int i = 0; i < n; i++) begin
            dot = longint'(q.x) * longint'(centroids[i].x)
                + longint'(q.y) * longint'(centroids[i].y)
                + longint'(q.z) * longint'(centroids[i].z);
            // strictly greater: lower slot keeps a tie
            if (dot > best) begin
              best = dot;
              want.index = IndexW'(i);
            end
          end
          want.score = ScoreW'(best);
          pending_matches.push_back(want);
        end
      end
      if (word_taken || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("watchdog: %0d cycles without progress", stall_cycles);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  function automatic comp_t rand_comp();
    case ($urandom_range(3))
      0: return comp_t'($urandom);
      1: begin
        case ($urandom_range(3))
          0:       return QMin;
          1:       return QMax;
          2:       return QZero;
          default: return 16'shffff;
        endcase
      end
      2: return comp_t'($urandom_range(1024)) - 16'sd512;
      default: begin
        if ($urandom_range(1)) return comp_t'(30000 + $urandom_range(2767));
        return comp_t'(-30000 - int'($urandom_range(2768)));
      end
    endcase
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    v.x = rand_comp();
    v.y = rand_comp();
    v.z = rand_comp();
    return v;
  endfunction

  function automatic vec_t mk_vec(comp_t x, comp_t y, comp_t z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  task automatic push_cmd(op_e op, int slot, vec_t v);
    plate_cmd_t c;
    c.op   = op;
    c.slot = SlotW'(slot);
    c.v    = v;
    if (op == OpLoad) begin
      shadow[slot] = v;
      seeded[slot] = 1'b1;
      n_loads++;
    end else begin
      n_queries++;
    end
    cmd_queue.push_back(c);
  endtask

  // queries only search slots already loaded; holes are filled first
  task automatic queue_random(int n, int eff);
    int   hole;
    int   slot;
    int   src;
    vec_t v;
    repeat (n) begin
      hole = -1;
      for (int i = eff - 1; i >= 0; i--) begin
        if (!seeded[i]) hole = i;
      end
      if (hole >= 0) begin
        push_cmd(OpLoad, hole, rand_vec());
      end else if ($urandom_range(99) < 35) begin
        slot = $urandom_range(NumSlots - 1);
        src  = $urandom_range(NumSlots - 1);
        v    = ($urandom_range(5) == 0 && seeded[src]) ? shadow[src] : rand_vec();
        push_cmd(OpLoad, slot, v);
      end else begin
        v = ($urandom_range(3) == 0) ? shadow[$urandom_range(eff - 1)] : rand_vec();
        push_cmd(OpClassify, $urandom_range(NumSlots - 1), v);
      end
    end
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || start || busy || pending_matches.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_plate_count(logic [NumPlatesW-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int plates, int pct, int n, bit pause);
    write_plate_count(NumPlatesW'(plates));
    idle_pct = pct;
    queue_random(n, plates == 0 ? 1 : (plates > NumSlots ? NumSlots : plates));
    if (pause) begin
      // let every pending result come back before sending more
      while (cmd_queue.size() > n / 2) @(posedge clk_i);
      hold = 1'b1;
      while (start || busy || pending_matches.size() != 0) @(posedge clk_i);
      hold = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    // one plate searched after reset
    push_cmd(OpLoad, 0, mk_vec(QMin, QMin, QMin));
    push_cmd(OpClassify, 0, mk_vec(QMin, QMin, QMin));
    push_cmd(OpClassify, 31, mk_vec(QMax, QMax, QMax));
    push_cmd(OpClassify, 0, mk_vec(QZero, QZero, QZero));
    push_cmd(OpClassify, 0, mk_vec(QMax, QMin, QZero));
    push_cmd(OpLoad, 1, mk_vec(QMin, QMin, QMin));
    push_cmd(OpLoad, 2, mk_vec(QMax, QZero, QZero));
    push_cmd(OpLoad, 31, mk_vec(QZero, QZero, QMax));

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_plate_count(NumPlatesW'(2));
    push_cmd(OpClassify, 0, mk_vec(QMin, QMin, QMin));
    push_cmd(OpClassify, 0, mk_vec(QMax, QMax, QMax));
    push_cmd(OpLoad, 1, mk_vec(QMax, QZero, QZero));
    push_cmd(OpClassify, 0, mk_vec(QMax, QZero, QZero));

    write_plate_count(NumPlatesW'(0));
    push_cmd(OpClassify, 0, mk_vec(QMax, QZero, QZero));
    push_cmd(OpClassify, 0, mk_vec(QZero, QMin, QZero));
    wait_idle();

    mid_plates = $urandom_range(31, 3);
    run_phase(NumSlots, 0, 120, 1'b0);
    run_phase(63, 63, 110, 1'b0);
    run_phase(mid_plates, 0, 110, 1'b1);
    run_phase(1, 32, 110, 1'b0);

    mismatches += pending_matches.size();
    $display("Ran %0d centroid loads and %0d queries; %0d results checked.",
             n_loads, n_queries, n_results);
    $display("Plate counts used: 1, 2, 0, 32, 63, %0d, 1; sender idle 0/63/0/32 pct.",
             mid_plates);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ncc_pkg.sv
src/ncc_table.sv
src/ncc_dot_unit.sv
src/ncc_seq.sv
src/nearest_centroid_classifier_unit.sv
src/ncc_checker.sv
test/nearest_centroid_classifier_unit_test.sv
